// ===== rtl/wsenc_pkg.sv =====
package wsenc_pkg;

  localparam int unsigned HdrMax = 8;
  localparam int unsigned IdxW = $clog2(HdrMax);

  localparam logic [15:0] SHORT_LENGTH_MAX = 16'd125;
  localparam logic [7:0] FIN_BIT = 8'h80;
  localparam logic [7:0] OP_TEXT = 8'h01;
  localparam logic [7:0] MASK_BIT = 8'h80;
  localparam logic [7:0] LEN_EXT16 = 8'd126;
  localparam logic [7:0] HDR_BYTE0 = FIN_BIT | OP_TEXT;

  // item kinds carried in tuser
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // one item's worth of output bytes, byte 0 goes out first
  typedef struct packed {
    logic [HdrMax-1:0][7:0] bytes;
    logic [IdxW-1:0] last_idx;
    logic hdr;
    logic fend;
    logic unexp;
  } burst_t;

endpackage

// ===== rtl/wsenc_frame.sv =====
module wsenc_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               kind,
  input  logic [15:0]        payload_length,
  input  logic [31:0]        mask_key,
  input  logic [7:0]         payload_byte,
  output wsenc_pkg::burst_t  burst
);
  import wsenc_pkg::*;

  logic [15:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [31:0] current_mask_r, current_mask_nxt;
  logic [1:0]  mask_position_r, mask_position_nxt;
  logic        frame_open_r, frame_open_nxt;

  logic [7:0]  mbyte;
  logic [15:0] remain_dec;
  logic        long_len;

  assign mbyte = current_mask_r[{mask_position_r, 3'b000} +: 8];
  assign remain_dec = bytes_remaining_r - 16'd1;
  assign long_len = payload_length > SHORT_LENGTH_MAX;

  always_comb begin
    burst = '0;
    bytes_remaining_nxt = bytes_remaining_r;
    current_mask_nxt = current_mask_r;
    mask_position_nxt = mask_position_r;
    frame_open_nxt = frame_open_r;
    if (kind == KIND_START) begin
      burst.hdr = 1'b1;
      burst.bytes[0] = HDR_BYTE0;
      if (long_len) begin
        burst.bytes[1] = MASK_BIT | LEN_EXT16;
        burst.bytes[2] = payload_length[15:8];
        burst.bytes[3] = payload_length[7:0];
        burst.bytes[4] = mask_key[7:0];
        burst.bytes[5] = mask_key[15:8];
        burst.bytes[6] = mask_key[23:16];
        burst.bytes[7] = mask_key[31:24];
        burst.last_idx = IdxW'(7);
      end else begin
        burst.bytes[1] = MASK_BIT | payload_length[7:0];
        burst.bytes[2] = mask_key[7:0];
        burst.bytes[3] = mask_key[15:8];
        burst.bytes[4] = mask_key[23:16];
        burst.bytes[5] = mask_key[31:24];
        burst.last_idx = IdxW'(5);
      end
      burst.fend = (payload_length == 16'd0);
      current_mask_nxt = mask_key;
      mask_position_nxt = 2'd0;
      bytes_remaining_nxt = payload_length;
      frame_open_nxt = (payload_length != 16'd0);
    end else if (!frame_open_r) begin
      burst.bytes[0] = payload_byte;
      burst.unexp = 1'b1;
    end else begin
      burst.bytes[0] = payload_byte ^ mbyte;
      burst.fend = (remain_dec == 16'd0);
      mask_position_nxt = mask_position_r + 2'd1;
      bytes_remaining_nxt = remain_dec;
      frame_open_nxt = (remain_dec != 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_remaining_r <= '0;
      current_mask_r <= '0;
      mask_position_r <= '0;
      frame_open_r <= 1'b0;
    end else if (accept) begin
      bytes_remaining_r <= bytes_remaining_nxt;
      current_mask_r <= current_mask_nxt;
      mask_position_r <= mask_position_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

// ===== rtl/wsenc_burst.sv =====
module wsenc_burst (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wsenc_pkg::burst_t burst,
  output logic              done,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic [2:0]        out_tuser
);
  import wsenc_pkg::*;

  logic             valid_r;
  logic [IdxW-1:0]  pos_r;
  burst_t           buf_r;
  logic             at_last;

  assign at_last = (pos_r == buf_r.last_idx);
  // buffer frees up in this cycle (empty, or last byte leaving)
  assign done = !valid_r || (out_tready && at_last);

  assign out_tvalid = valid_r;
  assign out_tdata = buf_r.bytes[pos_r];
  assign out_tlast = at_last;
  assign out_tuser = {buf_r.unexp, buf_r.fend && at_last, buf_r.hdr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      pos_r <= '0;
    end else if (valid_r && out_tready) begin
      if (at_last) begin
        valid_r <= 1'b0;
      end else begin
        pos_r <= pos_r + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= burst;
    end
  end

endmodule

// ===== rtl/websocket_client_frame_encoder_core.sv =====
// output: first result byte is registered, shown in the cycle after the input transfer
// throughput: one output byte per cycle while out_tready is high; payload items one per
// cycle while out_tready is high; a start item loads a 6-byte header (length up to 125)
// or an 8-byte one (extended length), and the next item waits while the single output byte lane drains it
// reset: synchronous active low, clears frame state and empties the output buffer
module websocket_client_frame_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // payload_length[15:0], mask_key[47:16], payload_byte[55:48]
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,  // run_last: last byte caused by one input transfer
  output logic [2:0]  out_tuser   // is_header[0], frame_end[1], unexpected_byte[2]
);
  import wsenc_pkg::*;

  logic   accept;
  logic   buf_done;
  burst_t burst;

  // a new item may enter while the last byte of the previous burst leaves
  assign in_tready = buf_done;
  assign accept = in_tvalid && in_tready;

  // header build, payload masking and frame state
  wsenc_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .kind           (in_tuser[0]),
    .payload_length (in_tdata[15:0]),
    .mask_key       (in_tdata[47:16]),
    .payload_byte   (in_tdata[55:48]),
    .burst          (burst)
  );

  // result register, emits the burst one byte per transfer
  wsenc_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .burst      (burst),
    .done       (buf_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/wsenc_checker.sv =====
module wsenc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);
  import wsenc_pkg::*;

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed under stall");

  // a start transfer is followed by the frame's first header byte
  a_start_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == KIND_START |=>
      out_tvalid && out_tdata == HDR_BYTE0 && out_tuser[0] && !out_tlast)
    else $error("start did not produce header byte");

  // a payload transfer gives exactly one non-header byte
  a_payload_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == KIND_PAYLOAD |=>
      out_tvalid && out_tlast && !out_tuser[0])
    else $error("payload transfer gave wrong result shape");

  // frame end and error flags only on the last byte of a run
  a_flags_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1] || out_tuser[2]) |-> out_tlast)
    else $error("frame end or error flag before run end");

  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0] && !out_tuser[1])
    else $error("error flag on header or frame end byte");

endmodule

bind websocket_client_frame_encoder_core wsenc_checker u_wsenc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
